### rtl/assert_macros.svh
// assertion macros used by the find and replace rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on clk, disabled while rst_n is low
`define FSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fsr assertion failed");

// condition that must never hold
`define FSR_ASSERT_NEVER(lbl, cond) \
  `FSR_ASSERT(lbl, !(cond))

`endif

### rtl/fsr_pkg.sv
// types and constants of the streaming find and replace block
package fsr_pkg;

  localparam int CHAR_W    = 8;
  localparam int TEXT_W    = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int BYTE_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_TEXT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_TEXT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN  = 2'd3;

  typedef enum logic [1:0] {
    OP_CHAR,
    OP_PASS,
    OP_EOL
  } fsr_op_t;

  typedef struct packed {
    fsr_op_t           op;
    logic [CHAR_W-1:0] ch;
  } fsr_item_t;

  typedef struct packed {
    logic [TEXT_W-1:0] key_text;
    logic [LEN_W-1:0]  key_len;
    logic [TEXT_W-1:0] repl_text;
    logic [LEN_W-1:0]  repl_len;
  } fsr_cfg_t;

endpackage

### rtl/fsr_stream_if.sv
// valid/ready channel interfaces for text input and result output
interface fsr_in_if import fsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface fsr_out_if import fsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              out_line_end;
  logic              last_of_run;

  modport source (output valid, output out_char, output out_line_end,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_char, input out_line_end,
                  input last_of_run, output ready);
endinterface

### rtl/fsr_front.sv
// front stage: accepts input requests and classifies them
module fsr_front import fsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fsr_in_if.sink    in_ch,
  input  logic      key_empty,
  output logic      item_v,
  output fsr_item_t item,
  input  logic      item_rdy
);

  logic      v_r;
  logic      v_nxt;
  fsr_item_t item_r;
  fsr_item_t item_nxt;

  assign in_ch.ready = !v_r || item_rdy;
  assign v_nxt       = in_ch.ready ? in_ch.valid : v_r;

  always_comb begin
    item_nxt.ch = in_ch.char_code;
    if (in_ch.line_end) begin
      item_nxt.op = OP_EOL;
    end else if (key_empty) begin
      item_nxt.op = OP_PASS;
    end else begin
      item_nxt.op = OP_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (in_ch.valid && in_ch.ready) begin
      item_r <= item_nxt;
    end
  end

  assign item_v = v_r;
  assign item   = item_r;

endmodule

### rtl/fsr_queue.sv
// two entry queue between the front and back stages
module fsr_queue import fsr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_v,
  input  fsr_item_t push_item,
  output logic      push_rdy,
  output logic      pop_v,
  output fsr_item_t pop_item,
  input  logic      pop_rdy
);

  fsr_item_t  mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;

  assign push_rdy = (cnt_r != 2'd2);
  assign pop_v    = (cnt_r != 2'd0);
  assign pop_item = mem_r[rd_ptr_r];
  assign push     = push_v && push_rdy;
  assign pop      = pop_v && pop_rdy;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/fsr_back.sv
// back stage: holds the candidate match and emits results at most one per cycle, stalled by back-pressure
`include "assert_macros.svh"

module fsr_back import fsr_pkg::*; #(
  parameter int KEY_MAX     = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  fsr_cfg_t  cfg,
  input  logic      cfg_clear,
  input  logic      q_v,
  input  fsr_item_t q_item,
  output logic      q_pop,
  fsr_out_if.source out_ch
);

  localparam int CNT_W = $clog2(KEY_MAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REPL,
    ST_FLUSH
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [CHAR_W-1:0] held_r   [KEY_MAX];
  logic [CHAR_W-1:0] held_nxt [KEY_MAX];
  logic [CHAR_W-1:0] held_sh  [KEY_MAX];
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  cnt_m1;
  logic [LEN_W-1:0]  ridx_r;
  logic [LEN_W-1:0]  ridx_nxt;

  logic              out_v_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_le_r;
  logic              out_last_r;

  logic              emit;
  logic [CHAR_W-1:0] e_char;
  logic              e_le;
  logic              e_last;
  logic              emit_ok;

  logic [LEN_W-1:0]  klen;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W-1:0]  cnt_ext;
  logic [LEN_W-1:0]  cnt_m1_ext;
  logic              pre;
  logic              sh_pre;
  logic              drop_last;
  logic              repl_last;

  assign klen = (cfg.key_len > LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX) : cfg.key_len;
  assign rlen = (cfg.repl_len > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : cfg.repl_len;

  assign cnt_m1     = cnt_r - CNT_W'(1);
  assign cnt_ext    = LEN_W'(cnt_r);
  assign cnt_m1_ext = LEN_W'(cnt_m1);
  assign emit_ok    = !out_v_r || out_ch.ready;
  assign repl_last  = (ridx_r == rlen - LEN_W'(1));

  // held characters against the key, now and after dropping the oldest
  always_comb begin
    pre    = (cnt_ext <= klen);
    sh_pre = (cnt_m1_ext <= klen);
    for (int i = 0; i < KEY_MAX; i++) begin
      if ((CNT_W'(i) < cnt_r) && (held_r[i] != cfg.key_text[i*CHAR_W +: CHAR_W])) begin
        pre = 1'b0;
      end
    end
    for (int i = 0; i < KEY_MAX - 1; i++) begin
      if ((CNT_W'(i + 1) < cnt_r) &&
          (held_r[i + 1] != cfg.key_text[i*CHAR_W +: CHAR_W])) begin
        sh_pre = 1'b0;
      end
    end
    drop_last = sh_pre && !((cnt_m1_ext == klen) && (rlen != '0));
  end

  always_comb begin
    for (int i = 0; i < KEY_MAX - 1; i++) begin
      held_sh[i] = held_r[i + 1];
    end
    held_sh[KEY_MAX - 1] = held_r[KEY_MAX - 1];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ridx_nxt  = ridx_r;
    held_nxt  = held_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    e_char    = '0;
    e_le      = 1'b0;
    e_last    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_v) begin
          case (q_item.op)
            OP_CHAR: begin
              q_pop     = 1'b1;
              state_nxt = ST_CHECK;
              if (cnt_ext >= LEN_W'(KEY_MAX)) begin
                held_nxt[0] = q_item.ch;
                cnt_nxt     = CNT_W'(1);
              end else begin
                for (int i = 0; i < KEY_MAX; i++) begin
                  if (CNT_W'(i) == cnt_r) begin
                    held_nxt[i] = q_item.ch;
                  end
                end
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            OP_PASS: begin
              if (emit_ok) begin
                q_pop   = 1'b1;
                emit    = 1'b1;
                e_char  = q_item.ch;
                e_last  = 1'b1;
                cnt_nxt = '0;
              end
            end
            OP_EOL: begin
              q_pop     = 1'b1;
              state_nxt = ST_FLUSH;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (!pre) begin
          if (emit_ok) begin
            emit     = 1'b1;
            e_char   = held_r[0];
            e_last   = drop_last;
            held_nxt = held_sh;
            cnt_nxt  = cnt_m1;
          end
        end else if (cnt_ext == klen) begin
          cnt_nxt   = '0;
          ridx_nxt  = '0;
          state_nxt = (rlen != '0) ? ST_REPL : ST_IDLE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPL: begin
        if (emit_ok) begin
          emit     = 1'b1;
          e_char   = cfg.repl_text[ridx_r[BYTE_IDX_W-1:0]*CHAR_W +: CHAR_W];
          e_last   = repl_last;
          ridx_nxt = ridx_r + LEN_W'(1);
          if (repl_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (cnt_r != '0) begin
            e_char   = held_r[0];
            held_nxt = held_sh;
            cnt_nxt  = cnt_m1;
          end else begin
            e_le      = 1'b1;
            e_last    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_clear) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
    ridx_r <= ridx_nxt;
    held_r <= held_nxt;
    if (emit) begin
      out_char_r <= e_char;
      out_le_r   <= e_le;
      out_last_r <= e_last;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_char     = out_char_r;
  assign out_ch.out_line_end = out_le_r;
  assign out_ch.last_of_run  = out_last_r;

  `FSR_ASSERT(a_held_proper_prefix, (state_r == ST_IDLE && klen != '0) |-> (cnt_ext < klen))
  `FSR_ASSERT(a_marker_ends_run, (out_v_r && out_le_r) |-> (out_last_r && out_char_r == '0))
  `FSR_ASSERT_NEVER(a_repl_with_held, state_r == ST_REPL && cnt_r != '0)

endmodule

### rtl/streaming_find_replace.sv
// top level of the streaming find and replace block
// order: an accepted request is registered in the front stage and then in the queue before
// the back stage pops it; a pass-through result is registered as it is popped, other results
// come from the check, replacement and flush states; the front stage and queue take new
// requests while the back stage works; at most one result per cycle, stalled by back-pressure
// reset: clears control state and the configuration, the held characters and data registers are not cleared
module streaming_find_replace import fsr_pkg::*; #(
  parameter int KEY_MAX     = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fsr_in_if.sink               in_ch,
  fsr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TEXT_W-1:0]    cfg_wdata
);

  fsr_cfg_t  cfg_r;
  fsr_cfg_t  cfg_nxt;
  logic      cfg_clear;
  logic      f_v;
  fsr_item_t f_item;
  logic      f_rdy;
  logic      q_v;
  fsr_item_t q_item;
  logic      q_pop;

  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_KEY_TEXT: begin
          cfg_nxt.key_text = cfg_wdata;
          cfg_clear        = 1'b1;
        end
        REG_KEY_LEN: begin
          cfg_nxt.key_len = cfg_wdata[LEN_W-1:0];
          cfg_clear       = 1'b1;
        end
        REG_REPL_TEXT: begin
          cfg_nxt.repl_text = cfg_wdata;
        end
        REG_REPL_LEN: begin
          cfg_nxt.repl_len = cfg_wdata[LEN_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .key_empty (cfg_r.key_len == '0),
    .item_v    (f_v),
    .item      (f_item),
    .item_rdy  (f_rdy)
  );

  fsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_v    (f_v),
    .push_item (f_item),
    .push_rdy  (f_rdy),
    .pop_v     (q_v),
    .pop_item  (q_item),
    .pop_rdy   (q_pop)
  );

  fsr_back #(
    .KEY_MAX     (KEY_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_clear (cfg_clear),
    .q_v       (q_v),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

### tb/sv/fsr_checker.sv
// checker that predicts the replaced text stream and compares every result of the block
module fsr_checker import fsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fsr_in_if                    in_ch,
  fsr_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TEXT_W-1:0]    cfg_wdata,
  output int                   mismatches,
  output int                   outstanding,
  output int                   results_checked,
  output int                   matches_replaced
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_MAX     = 8;
  localparam int REPLACE_MAX = 8;
  localparam int RUN_MAX     = KEY_MAX + REPLACE_MAX + 1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              line_end;
    logic              last;
  } text_result_t;

  text_result_t      expected_text[$];
  text_result_t      oldest;
  logic [TEXT_W-1:0] key_text;
  logic [LEN_W-1:0]  key_len;
  logic [TEXT_W-1:0] repl_text;
  logic [LEN_W-1:0]  repl_len;
  logic [CHAR_W-1:0] held [KEY_MAX];
  int                held_n;

  function automatic logic [CHAR_W-1:0] text_byte(input logic [TEXT_W-1:0] word, input int i);
    return word[i*CHAR_W +: CHAR_W];
  endfunction

  function automatic bit held_is_key_prefix(input int klen);
    if (held_n > klen) return 1'b0;
    for (int i = 0; i < held_n; i++) begin
      if (held[i] != text_byte(key_text, i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic replace_step(input logic [CHAR_W-1:0] c, input logic le);
    text_result_t run [RUN_MAX];
    int           n;
    int           klen;
    int           rlen;
    n = 0;
    klen = (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
    rlen = (repl_len > REPLACE_MAX) ? REPLACE_MAX : int'(repl_len);
    if (le) begin
      for (int i = 0; i < held_n; i++) begin
        run[n] = '{held[i], 1'b0, 1'b0};
        n++;
      end
      held_n = 0;
      run[n] = '{'0, 1'b1, 1'b0};
      n++;
    end else if (klen == 0) begin
      held_n = 0;
      run[n] = '{c, 1'b0, 1'b0};
      n++;
    end else begin
      if (held_n >= KEY_MAX) held_n = 0;
      held[held_n] = c;
      held_n++;
      // drop the oldest held character until the rest is a key prefix again
      while (held_n > 0 && !held_is_key_prefix(klen)) begin
        run[n] = '{held[0], 1'b0, 1'b0};
        n++;
        for (int i = 0; i < KEY_MAX - 1; i++) held[i] = held[i+1];
        held_n--;
      end
      if (held_n == klen) begin
        for (int i = 0; i < rlen; i++) begin
          run[n] = '{text_byte(repl_text, i), 1'b0, 1'b0};
          n++;
        end
        held_n = 0;
        matches_replaced++;
      end
    end
    if (n > 0) run[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_text.insert(expected_text.size(), run[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_text = '0;
      key_len = '0;
      repl_text = '0;
      repl_len = '0;
      held_n = 0;
      expected_text.delete();
      mismatches = 0;
      results_checked = 0;
      matches_replaced = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected result: out_char %0h, out_line_end %0b, last_of_run %0b",
                 out_ch.out_char, out_ch.out_line_end, out_ch.last_of_run);
          mismatches++;
        end else begin
          oldest = expected_text.pop_front();
          results_checked++;
          if (out_ch.out_char !== oldest.ch) begin
            $error("out_char: expected %0h, actual %0h", oldest.ch, out_ch.out_char);
            mismatches++;
          end
          if (out_ch.out_line_end !== oldest.line_end) begin
            $error("out_line_end: expected %0b, actual %0b", oldest.line_end,
                   out_ch.out_line_end);
            mismatches++;
          end
          if (out_ch.last_of_run !== oldest.last) begin
            $error("last_of_run: expected %0b, actual %0b", oldest.last, out_ch.last_of_run);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_TEXT: begin
            key_text = cfg_wdata;
            held_n = 0;
          end
          REG_KEY_LEN: begin
            key_len = cfg_wdata[LEN_W-1:0];
            held_n = 0;
          end
          REG_REPL_TEXT: repl_text = cfg_wdata;
          REG_REPL_LEN: repl_len = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) replace_step(in_ch.char_code, in_ch.line_end);
    end
    outstanding = expected_text.size();
  end

endmodule

### tb/sv/tb_streaming_find_replace.sv
// testbench top for the streaming find and replace block: clock, reset, text requests, verdict
module tb_streaming_find_replace import fsr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 38;
  localparam int KEY_LENS  [PHASES] = '{1, 8, 2, 0, 15, 3, 5, 4, 6};
  localparam int REPL_LENS [PHASES] = '{0, 8, 3, 1, 12, 2, 15, 5, 4};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TEXT_W-1:0]    cfg_wdata;

  fsr_in_if  in_ch ();
  fsr_out_if out_ch ();

  int chk_mismatches;
  int chk_outstanding;
  int chk_checked;
  int chk_matches;

  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_request;
  bit                hold_done;
  int                requests_sent;
  int                key_settings;
  int                stall_cycles;
  logic [TEXT_W-1:0] cur_key_text;
  logic [LEN_W-1:0]  cur_key_len;

  streaming_find_replace dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fsr_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatches       (chk_mismatches),
    .outstanding      (chk_outstanding),
    .results_checked  (chk_checked),
    .matches_replaced (chk_matches)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [CHAR_W-1:0] c, input logic le);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.line_end <= le;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (chk_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEXT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_key(input logic [TEXT_W-1:0] text, input logic [TEXT_W-1:0] len_word);
    write_reg(REG_KEY_TEXT, text);
    write_reg(REG_KEY_LEN, len_word);
    cur_key_text = text;
    cur_key_len = len_word[LEN_W-1:0];
    key_settings++;
  endtask

  task automatic set_replacement(input logic [TEXT_W-1:0] text,
                                 input logic [TEXT_W-1:0] len_word);
    write_reg(REG_REPL_TEXT, text);
    write_reg(REG_REPL_LEN, len_word);
  endtask

  // mostly key fragments and whole keys, some random bytes and line ends
  task automatic send_text(input int n_items);
    int sent;
    int r;
    int kl;
    int plen;
    sent = 0;
    kl = (cur_key_len > 8) ? 8 : int'(cur_key_len);
    if (kl == 0) kl = 1;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_request(8'($urandom_range(255)), 1'b1);
        sent++;
      end else if (r < 35) begin
        for (int k = 0; k < kl; k++) send_request(cur_key_text[k*CHAR_W +: CHAR_W], 1'b0);
        sent += kl;
      end else if (r < 50) begin
        plen = $urandom_range(kl - 1);
        for (int k = 0; k < plen; k++) send_request(cur_key_text[k*CHAR_W +: CHAR_W], 1'b0);
        send_request(8'($urandom_range(255)), 1'b0);
        sent += plen + 1;
      end else if (r < 85) begin
        send_request(cur_key_text[$urandom_range(kl - 1)*CHAR_W +: CHAR_W], 1'b0);
        sent++;
      end else begin
        send_request(8'($urandom_range(255)), 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [TEXT_W-1:0] text;
    logic [TEXT_W-1:0] len_word;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_TEXT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.char_code = '0;
    in_ch.line_end = 1'b0;
    hold_request = 1'b0;
    requests_sent = 0;
    key_settings = 0;
    cur_key_text = '0;
    cur_key_len = '0;
    send_idle_pct = 26;
    recv_idle_pct = 49;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty key after reset: plain pass-through, ignored char on line end
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'hA5, 1'b1);
    send_request(8'h00, 1'b1);

    // short key: match, broken prefix, flush, key rewrite mid-line
    wait_drained();
    set_key(64'h636261, 64'd3);
    set_replacement(64'h5958, 64'd2);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h63, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h63, 1'b0);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    wait_drained();
    write_reg(REG_KEY_TEXT, 64'h636261);
    send_request(8'h00, 1'b1);

    // oversized key and replacement lengths clamp to eight
    wait_drained();
    set_key(64'h00FF_7F80_0102_FE01, 64'd15);
    set_replacement(64'hA1B2_C3D4_E5F6_0718, 64'd12);
    for (int k = 0; k < 8; k++) send_request(cur_key_text[k*CHAR_W +: CHAR_W], 1'b0);

    // empty replacement deletes the match
    wait_drained();
    set_key(64'h78, 64'd1);
    write_reg(REG_REPL_LEN, 64'd0);
    send_request(8'h78, 1'b0);
    send_request(8'h00, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_drained();
      if ($urandom_range(1)) begin
        for (int k = 0; k < 8; k++) text[k*CHAR_W +: CHAR_W] = $urandom_range(1) ? 8'h61 : 8'h62;
      end else begin
        text = {$urandom(), $urandom()};
      end
      len_word = {$urandom(), $urandom()};
      len_word[LEN_W-1:0] = LEN_W'(KEY_LENS[p]);
      set_key(text, len_word);
      len_word = {$urandom(), $urandom()};
      len_word[LEN_W-1:0] = LEN_W'(REPL_LENS[p]);
      set_replacement({$urandom(), $urandom()}, len_word);
      if (p == 1) hold_request = 1'b1;
      if (p == 4) begin
        send_text(PHASE_ITEMS / 2);
        wait_drained();
        send_text(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        send_text(PHASE_ITEMS);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("covered %0d text requests under %0d key settings, including clamped lengths,",
             requests_sent, key_settings);
    $display("empty key and replacement, back-pressure; %0d results checked, %0d matches replaced",
             chk_checked, chk_matches);
    if (chk_mismatches == 0 && chk_outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/fsr_pkg.sv
rtl/fsr_stream_if.sv
rtl/fsr_front.sv
rtl/fsr_queue.sv
rtl/fsr_back.sv
rtl/streaming_find_replace.sv
tb/sv/fsr_checker.sv
tb/sv/tb_streaming_find_replace.sv
